FILE: rtl/core/ppq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types, codes and constants of the packet pacer queue.
// ----------------------------------------------------------------------------
package ppq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 2048;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int TIME_W  = 48;
  localparam int CHAN_W  = 3;
  localparam int BYTES_W = 16;
  localparam int HDL_W   = 16;
  localparam int OCC_W   = 12;
  localparam int STAT_W  = 3;
  localparam int RATE_W  = 31;
  localparam int BURST_W = 20;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BITRATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST   = 2'd1;
  localparam logic [RATE_W-1:0]    BITRATE_RST = 31'd6291456;
  localparam logic [BURST_W-1:0]   BURST_RST   = 20'd4000;

  // Pacing arithmetic: delay = bytes * 8 * 1e6 / rate.
  localparam int US_PER_S_W = 20;
  localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;
  localparam int BYTE_SHIFT = 3;
  localparam int PROD_W     = BYTES_W + US_PER_S_W;
  localparam int DVD_W      = PROD_W + BYTE_SHIFT;
  localparam int REM_W      = RATE_W + 1;
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  // Function codes.
  localparam logic FUNC_ENQ  = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_DUE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_DISCARD  = 3'd4;

  typedef struct packed {
    logic               func;
    logic [TIME_W-1:0]  now_us;
    logic [CHAN_W-1:0]  channel;
    logic [BYTES_W-1:0] pkt_bytes;
    logic [HDL_W-1:0]   handle;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CHAN_W-1:0]  out_channel;
    logic [BYTES_W-1:0] out_bytes;
    logic [HDL_W-1:0]   out_handle;
    logic [TIME_W-1:0]  send_time_us;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  // One queue entry as held in the descriptor memory.
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [CHAN_W-1:0]  channel;
    logic [BYTES_W-1:0] pkt_bytes;
    logic [HDL_W-1:0]   handle;
  } entry_t;

  // Divider handshake.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_ADV,
    S_POLL,
    S_OUT
  } ppq_state_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

FILE: rtl/core/ppq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppq_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppq_pkg::div_req_t        req,
  input  logic [ppq_pkg::DVD_W-1:0]  dividend,
  input  logic [ppq_pkg::RATE_W-1:0] divisor,
  output ppq_pkg::div_rsp_t        rsp
);
  import ppq_pkg::*;

  logic [REM_W-1:0]     rem_r;
  logic [DVD_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [REM_W-1:0]     shifted;
  logic [REM_W:0]       diff;
  logic                 ge;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_r[REM_W-2:0], quo_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = ~diff[REM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit is shifted in.
      done_r <= run_r & ~req.start & (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= ge ? diff[REM_W-1:0] : shifted;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/core/ppq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_store
// Descriptor memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppq_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ppq_pkg::PTR_W-1:0] wr_addr,
  input  ppq_pkg::entry_t           wr_data,
  input  logic                      rd_en,
  input  logic [ppq_pkg::PTR_W-1:0] rd_addr,
  output ppq_pkg::entry_t           rd_data
);
  import ppq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/packet_pacer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_pacer_queue_core
// Leaky-bucket pacer in front of a descriptor queue: stamps enqueued packets
// with a paced send time and releases the head once that time has come.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_ready | in_item  (func, now, packet)
//   out     | output    | out_valid/out_ready | out_item (status, entry, occ)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An enqueue item steps through S_MUL, S_DIVGO, S_DIV and S_ADV to S_OUT,
// and the next item is taken back in S_IDLE; in S_DIV the bit-serial divider
// produces one of the 39 quotient bits of bytes * 8e6 / rate per cycle. A poll
// item steps through S_POLL to S_OUT, straight to S_OUT on an empty queue;
// S_POLL waits for the registered read of the descriptor memory.
// Reset (rst_n low, synchronous) empties the queue, clears the schedule and
// loads the default rate and burst registers. The memory itself is not
// cleared; only entries counted as occupied ever reach a result.
// One item is worked on at a time. A finished result sits in the output
// register while the next item is accepted; a stalled output holds the
// following item in its last step until the register frees up.
// ----------------------------------------------------------------------------
module packet_pacer_queue_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ppq_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppq_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppq_pkg::*;

  // Control state.
  ppq_state_t        state_r, state_nxt;
  logic [RATE_W-1:0]  bitrate_r;
  logic [BURST_W-1:0] burst_r;
  logic [TIME_W-1:0]  nst_r;
  logic [PTR_W-1:0]   head_r;
  logic [PTR_W-1:0]   tail_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;

  // Per-item working registers.
  in_item_t           item_r;
  logic [TIME_W-1:0]  stamp_r;
  logic [PROD_W-1:0]  prod_r;
  logic [TIME_W-1:0]  adv_r;
  out_item_t          res_r;
  out_item_t          out_r;

  // Datapath nets.
  logic               in_acc;
  logic               out_free;
  logic               full;
  logic               rd_en;
  logic               wr_en;
  logic               out_load;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [RATE_W-1:0]  divisor;
  logic [DVD_W-1:0]   dividend;
  logic [TIME_W-1:0]  limit;
  logic [TIME_W-1:0]  raised;
  logic [TIME_W-1:0]  stamp;
  logic [DVD_W-1:0]   delay;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               head_due;
  out_item_t          res_empty;

  assign in_acc    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign cfg_ready = 1'b1;

  // A zero rate register paces as one bit per second.
  assign divisor  = (bitrate_r == '0) ? RATE_W'(1) : bitrate_r;
  assign dividend = {prod_r, {BYTE_SHIFT{1'b0}}};

  // Schedule is first raised to now, then held within the burst cap of now.
  assign limit  = sat_add48(item_r.now_us, TIME_W'(burst_r));
  assign raised = (nst_r < item_r.now_us) ? item_r.now_us : nst_r;
  assign stamp  = (raised > limit) ? limit : raised;

  // Every packet advances the schedule by at least one microsecond.
  assign delay = (div_rsp.quotient == '0) ? DVD_W'(1) : div_rsp.quotient;

  assign wr_entry.stamp     = stamp_r;
  assign wr_entry.channel   = item_r.channel;
  assign wr_entry.pkt_bytes = item_r.pkt_bytes;
  assign wr_entry.handle    = item_r.handle;

  assign head_due = (rd_entry.stamp <= item_r.now_us);

  // Poll of an empty queue: nothing due, only occupancy reported.
  always_comb begin
    res_empty           = '0;
    res_empty.status    = ST_NOT_DUE;
    res_empty.occupancy = OCC_W'(cnt_r);
  end

  ppq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (dividend),
    .divisor  (divisor),
    .rsp      (div_rsp)
  );

  ppq_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_entry)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.func == FUNC_ENQ) begin
            state_nxt = S_MUL;
          end else if (cnt_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_POLL;
          end
        end
      end
      S_MUL:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV:  state_nxt = S_OUT;
      S_POLL: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        // The head read is issued with the poll item so its data lands in S_POLL.
        rd_en    = in_valid & (in_item.func == FUNC_POLL);
      end
      S_DIVGO: div_req.start = 1'b1;
      S_OUT: begin
        out_load = out_free;
        wr_en    = out_free & (item_r.func == FUNC_ENQ);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitrate_r <= BITRATE_RST;
      burst_r   <= BURST_RST;
    end else if (cfg_valid & cfg_ready) begin
      case (cfg_index)
        REG_BITRATE: bitrate_r <= cfg_data[RATE_W-1:0];
        REG_BURST:   burst_r   <= cfg_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // Queue pointers, occupancy and schedule commit when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nst_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (out_load) begin
      if (item_r.func == FUNC_ENQ) begin
        nst_r  <= adv_r;
        tail_r <= ptr_next(tail_r);
        if (full) begin
          head_r <= ptr_next(head_r);
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (res_r.status == ST_RELEASED || res_r.status == ST_DISCARD) begin
        head_r <= ptr_next(head_r);
        cnt_r  <= cnt_r - 1'b1;
      end
    end
  end

  // Per-item datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_r <= in_item;
          res_r  <= res_empty;
        end
      end
      S_MUL: begin
        prod_r  <= PROD_W'(item_r.pkt_bytes) * PROD_W'(US_PER_S);
        stamp_r <= stamp;
      end
      S_ADV: begin
        adv_r              <= sat_add48(stamp_r, TIME_W'(delay));
        res_r.status       <= full ? ST_DROPPED : ST_ENQUEUED;
        res_r.out_channel  <= item_r.channel;
        res_r.out_bytes    <= item_r.pkt_bytes;
        res_r.out_handle   <= item_r.handle;
        res_r.send_time_us <= stamp_r;
        res_r.occupancy    <= full ? OCC_W'(cnt_r) : OCC_W'(cnt_r + 1'b1);
      end
      S_POLL: begin
        res_r.send_time_us <= rd_entry.stamp;
        if (head_due) begin
          res_r.status      <= (rd_entry.pkt_bytes != '0) ? ST_RELEASED : ST_DISCARD;
          res_r.out_channel <= rd_entry.channel;
          res_r.out_bytes   <= rd_entry.pkt_bytes;
          res_r.out_handle  <= rd_entry.handle;
          res_r.occupancy   <= OCC_W'(cnt_r - 1'b1);
        end else begin
          res_r.status      <= ST_NOT_DUE;
          res_r.out_channel <= '0;
          res_r.out_bytes   <= '0;
          res_r.out_handle  <= '0;
          res_r.occupancy   <= OCC_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/core/ppq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_checker
// Port-level checks of the packet pacer queue, bound to the top level.
// ----------------------------------------------------------------------------
module ppq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input ppq_pkg::out_item_t             out_item
);
  import ppq_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // Occupancy never exceeds the queue depth.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.occupancy <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // A released entry has a size, a discarded one has none.
  a_release_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_RELEASED) |-> out_item.out_bytes != '0)
    else $error("zero-size entry reported as released");

  a_discard_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_DISCARD) |-> out_item.out_bytes == '0)
    else $error("sized entry reported as discarded");

endmodule

bind packet_pacer_queue_core ppq_checker u_ppq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet pacer queue: a predictor of the pacing
// schedule and descriptor queue checks every result item against what the
// block should produce under directed, random and time-saturating traffic.
// ----------------------------------------------------------------------------
module tb;
  import ppq_pkg::*;

  // Bench constants. The spare indexes address no register and must be
  // ignored by the block.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 2'd3;
  localparam logic [63:0]         BITS_IN_BYTE  = 64'd8;
  localparam logic [63:0]         MICROS_IN_SEC = 64'd1000000;
  localparam logic [TIME_W-1:0]   TIME_TOP      = {TIME_W{1'b1}};
  localparam logic [RATE_W-1:0]   RATE_TOP      = 31'd1073741824;
  localparam logic [RATE_W-1:0]   RATE_BOTTOM   = 31'd1024;
  localparam logic [BURST_W-1:0]  BURST_TOP     = 20'd1000000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  packet_pacer_queue_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Queues: packet commands still to be driven, results the pacer owes us,
  // and the predicted contents of the descriptor queue.
  in_item_t  queued_cmds[$];
  out_item_t due_results[$];
  entry_t    model_fifo[$];

  // Predicted pacer state and register copies.
  logic [TIME_W-1:0]  sched_time = '0;
  logic [RATE_W-1:0]  rate_reg   = BITRATE_RST;
  logic [BURST_W-1:0] burst_reg  = BURST_RST;
  logic [TIME_W-1:0]  now_cursor = '0;

  int   n_pushed   = 0;
  int   n_accepted = 0;
  int   n_results  = 0;
  int   fail_count = 0;
  int   cycle_cnt  = 0;
  logic in_fire_q  = 1'b0;
  logic out_fire_q = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor.
  // --------------------------------------------------------------------------

  // Time sums clamp at the top of the 48-bit range instead of wrapping.
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
  endfunction

  // Wire time of a packet at the current rate, never less than 1 us. A rate
  // register of zero counts as one bit per second.
  function automatic logic [TIME_W-1:0] wire_time_us(input logic [BYTES_W-1:0] nbytes);
    logic [63:0] rate;
    logic [63:0] quo;
    rate = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
    quo  = (64'(nbytes) * BITS_IN_BYTE * MICROS_IN_SEC) / rate;
    return (quo == 64'd0) ? TIME_W'(1) : quo[TIME_W-1:0];
  endfunction

  // Applies one command to the predicted state and returns its result item.
  task automatic pace_step(input in_item_t cmd, output out_item_t res);
    logic [TIME_W-1:0] cap_time;
    entry_t            ent;
    res = '0;
    if (cmd.func == FUNC_ENQ) begin
      // Raise the schedule to now, then hold it within the burst window.
      cap_time = add_sat(cmd.now_us, TIME_W'(burst_reg));
      if (sched_time < cmd.now_us) sched_time = cmd.now_us;
      if (sched_time > cap_time) sched_time = cap_time;
      ent.stamp     = sched_time;
      ent.channel   = cmd.channel;
      ent.pkt_bytes = cmd.pkt_bytes;
      ent.handle    = cmd.handle;
      sched_time    = add_sat(sched_time, wire_time_us(cmd.pkt_bytes));
      res.status    = ST_ENQUEUED;
      // A full queue gives up its oldest descriptor to make room.
      if (model_fifo.size() >= QUEUE_DEPTH) begin
        model_fifo.delete(0);
        res.status = ST_DROPPED;
      end
      model_fifo.insert(model_fifo.size(), ent);
      res.out_channel  = ent.channel;
      res.out_bytes    = ent.pkt_bytes;
      res.out_handle   = ent.handle;
      res.send_time_us = ent.stamp;
    end else if (model_fifo.size() == 0) begin
      res.status = ST_NOT_DUE;
    end else begin
      ent = model_fifo[0];
      res.send_time_us = ent.stamp;
      if (ent.stamp > cmd.now_us) begin
        // Head not due yet: only its stamp is reported, nothing leaves.
        res.status = ST_NOT_DUE;
      end else begin
        model_fifo.delete(0);
        res.out_channel = ent.channel;
        res.out_bytes   = ent.pkt_bytes;
        res.out_handle  = ent.handle;
        res.status      = (ent.pkt_bytes != '0) ? ST_RELEASED : ST_DISCARD;
      end
    end
    res.occupancy = OCC_W'(model_fifo.size());
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents one command item at a time, with a random gap drawn
  // after each accepted item. Stretches of back-to-back items come in runs.
  // --------------------------------------------------------------------------
  int in_gap      = 0;
  int in_run_left = 0;
  bit in_run_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (in_valid) begin
        if (in_run_left == 0) begin
          in_run_left = $urandom_range(1, 40);
          in_run_calm = ($urandom_range(0, 3) == 0);
        end
        in_run_left--;
        in_gap = in_run_calm ? 0 : $urandom_range(0, 7);
      end
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        in_item  <= queued_cmds[0];
        queued_cmds.delete(0);
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: after each result item it stalls out_ready for a random
  // number of cycles, again with calm stretches.
  int out_stall    = 0;
  int out_run_left = 0;
  bit out_run_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire_q) begin
        if (out_run_left == 0) begin
          out_run_left = $urandom_range(1, 40);
          out_run_calm = ($urandom_range(0, 3) == 0);
        end
        out_run_left--;
        out_stall = out_run_calm ? 0 : $urandom_range(0, 7);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction, then predicts
  // the command accepted at this edge. A command's result can never come back
  // at the edge that accepts it, so the order of the two is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t pred;
    in_fire_q  <= in_valid && in_ready;
    out_fire_q <= out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: st=%0d occ=%0d",
                     n_results, out_item.status, out_item.occupancy);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (out_item.status !== want.status ||
              out_item.out_channel !== want.out_channel ||
              out_item.out_bytes !== want.out_bytes ||
              out_item.out_handle !== want.out_handle ||
              out_item.send_time_us !== want.send_time_us ||
              out_item.occupancy !== want.occupancy) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("result %0d mismatch: want st=%0d ch=%0d len=%0d hdl=%h t=%0d occ=%0d",
                       n_results, want.status, want.out_channel, want.out_bytes,
                       want.out_handle, want.send_time_us, want.occupancy);
              $display("  got st=%0d ch=%0d len=%0d hdl=%h t=%0d occ=%0d",
                       out_item.status, out_item.out_channel, out_item.out_bytes,
                       out_item.out_handle, out_item.send_time_us, out_item.occupancy);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pace_step(in_item, pred);
        due_results.insert(due_results.size(), pred);
        n_accepted++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Registers are only written with the pacer idle, so the predictor copy is
  // updated at the accepting edge without disturbing any prediction.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_BITRATE) rate_reg = data[RATE_W-1:0];
    else if (idx == REG_BURST) burst_reg = data[BURST_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every command has been taken and answered.
  task automatic wait_idle();
    do @(negedge clk); while (!(n_accepted == n_pushed && n_results == n_accepted));
    repeat (8) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_cmd(input logic f, input logic [BYTES_W-1:0] nbytes,
                          input logic [CHAN_W-1:0] ch, input logic [HDL_W-1:0] hdl);
    in_item_t cmd;
    cmd.func      = f;
    cmd.now_us    = now_cursor;
    cmd.channel   = ch;
    cmd.pkt_bytes = nbytes;
    cmd.handle    = hdl;
    queued_cmds.insert(queued_cmds.size(), cmd);
    n_pushed++;
  endtask

  // Packet sizes lean toward real traffic, with empty and jumbo outliers.
  function automatic logic [BYTES_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return BYTES_W'($urandom_range(1, 64));
      7:       return BYTES_W'($urandom_range(1500, 9000));
      8:       return BYTES_W'($urandom_range(0, 65535));
      9:       return '1;
      default: return BYTES_W'($urandom_range(64, 1500));
    endcase
  endfunction

  // Time between commands: mostly short, so heads are often not yet due.
  function automatic logic [TIME_W-1:0] pick_step_us();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return TIME_W'($urandom_range(0, 200));
      8:          return TIME_W'($urandom_range(3000, 20000));
      9:          return '0;
      default:    return TIME_W'($urandom_range(200, 3000));
    endcase
  endfunction

  task automatic push_random(input int poll_pct);
    now_cursor = add_sat(now_cursor, pick_step_us());
    push_cmd(($urandom_range(0, 99) < poll_pct) ? FUNC_POLL : FUNC_ENQ, pick_len(),
             CHAN_W'($urandom_range(0, 7)), HDL_W'($urandom_range(0, 65535)));
  endtask

  task automatic run_random(input int count, input int poll_pct);
    for (int k = 0; k < count; k++) push_random(poll_pct);
    wait_idle();
  endtask

  // Random register values, with the unused upper data bits set at random.
  task automatic write_random_regs();
    logic [RATE_W-1:0]  rate;
    logic [BURST_W-1:0] burst;
    rate  = RATE_W'($urandom_range(RATE_BOTTOM, RATE_TOP));
    burst = BURST_W'($urandom_range(0, BURST_TOP));
    write_reg(REG_BITRATE, {1'($urandom_range(0, 1)), rate});
    write_reg(REG_BURST, {12'($urandom), burst});
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, directed. The time starts at zero.
    push_cmd(FUNC_POLL, '0, '0, '0);              // poll with nothing queued
    push_cmd(FUNC_ENQ, '0, '1, '1);               // empty packet, top channel
    push_cmd(FUNC_ENQ, '1, '0, '0);               // largest packet
    now_cursor = 10;
    push_cmd(FUNC_ENQ, 16'd1500, 3'd5, 16'h1234); // schedule clamped to burst
    push_cmd(FUNC_POLL, '0, '0, '0);              // empty head is discarded
    push_cmd(FUNC_POLL, '0, '0, '0);              // due head is released
    push_cmd(FUNC_POLL, '0, '0, '0);              // head not yet due
    now_cursor = 4010;
    push_cmd(FUNC_POLL, '0, '0, '0);              // due exactly now
    push_cmd(FUNC_POLL, '0, '0, '0);              // empty again
    push_cmd(FUNC_ENQ, 16'd1, 3'd3, 16'h00ff);    // shortest wire time
    push_cmd(FUNC_ENQ, 16'd1, 3'd4, 16'hff00);
    push_cmd(FUNC_POLL, '0, '0, '0);
    push_cmd(FUNC_POLL, '0, '0, '0);
    wait_idle();

    // Fastest rate and no burst window: every stamp lands on now, and small
    // packets take the one microsecond floor.
    write_reg(REG_BITRATE, CFG_DATA_W'(RATE_TOP));
    write_reg(REG_BURST, '0);
    push_cmd(FUNC_ENQ, 16'd1, 3'd1, 16'h0001);
    push_cmd(FUNC_ENQ, 16'd1, 3'd2, 16'h0002);
    push_cmd(FUNC_POLL, '0, '0, '0);
    run_random(70, 45);

    // Slowest legal rate with the widest burst window.
    write_reg(REG_BITRATE, CFG_DATA_W'(RATE_BOTTOM));
    write_reg(REG_BURST, CFG_DATA_W'(BURST_TOP));
    run_random(70, 50);

    // A zero rate register, reached through data with its top bit set; the
    // pacer must treat it as one bit per second.
    write_reg(REG_BITRATE, 32'h8000_0000);
    write_reg(REG_BURST, CFG_DATA_W'($urandom_range(0, BURST_TOP)));
    run_random(40, 50);

    // Writes to the spare indexes must leave both registers alone.
    write_reg(REG_BITRATE, CFG_DATA_W'(BITRATE_RST));
    write_reg(REG_BURST, CFG_DATA_W'(BURST_RST));
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_SPARE_TOP, $urandom);
    run_random(60, 45);

    for (int p = 0; p < 3; p++) begin
      write_random_regs();
      run_random(50, 40 + 5 * p);
    end

    // Near the top of the time range both the burst limit and the advanced
    // schedule saturate. Time never goes back, so this comes last.
    write_reg(REG_BITRATE, CFG_DATA_W'(RATE_BOTTOM));
    write_reg(REG_BURST, CFG_DATA_W'(BURST_TOP));
    now_cursor = TIME_TOP - TIME_W'(300000);
    push_cmd(FUNC_ENQ, '1, 3'd6, 16'h5a5a);
    push_cmd(FUNC_ENQ, '1, 3'd7, 16'ha5a5);
    push_cmd(FUNC_ENQ, 16'd1500, 3'd0, 16'h0f0f);
    for (int k = 0; k < 20; k++) push_random(50);
    now_cursor = TIME_TOP;
    push_cmd(FUNC_ENQ, 16'd64, 3'd2, 16'hbeef);
    push_cmd(FUNC_ENQ, '0, 3'd3, 16'hcafe);
    for (int k = 0; k < 30; k++) push_cmd(FUNC_POLL, '0, '0, '0);
    wait_idle();

    // Let any late or stray result show up before the verdict.
    repeat (60) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
